/* design/ranging_timing_budget_encoder_macros.svh */
// Assertion macros shared by the timing budget encoder modules.
`ifndef RANGING_TIMING_BUDGET_ENCODER_MACROS_SVH
`define RANGING_TIMING_BUDGET_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RTBE_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RTBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rtbe_pkg.sv */
// Types and constants shared by the timing budget encoder.
`default_nettype none

package rtbe_pkg;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;
    localparam int RES_W      = 106;

    // Budget limits in microseconds.
    localparam logic [20:0] GUARD_US     = 21'd4528;
    localparam logic [20:0] MAX_RANGE_US = 21'd1100000;

    // Arithmetic constants.
    localparam logic [31:0] PLL_NUMERATOR       = 32'h4000_0000;
    localparam logic [31:0] MACRO_VCSEL_PERIODS = 32'd2304;
    localparam logic [31:0] PHASECAL_US         = 32'd1000;
    localparam logic [31:0] PC_MAX              = 32'h0000_00FF;
    localparam logic [31:0] ENC_HIGH_MASK       = 32'hFFFF_FF00;
    localparam logic [63:0] ROUND_HALF          = 64'h0000_0000_0000_0800;
    localparam logic [31:0] GUARD_US_32         = 32'd4528;

    // Pulse-period codes by distance mode.
    localparam logic [3:0] CODE_SHORT_A  = 4'h7;
    localparam logic [3:0] CODE_SHORT_B  = 4'h5;
    localparam logic [3:0] CODE_MEDIUM_A = 4'hB;
    localparam logic [3:0] CODE_MEDIUM_B = 4'h9;
    localparam logic [3:0] CODE_LONG_A   = 4'hF;
    localparam logic [3:0] CODE_LONG_B   = 4'hD;

    // Distance mode values.
    localparam logic [1:0] MODE_SHORT  = 2'd0;
    localparam logic [1:0] MODE_MEDIUM = 2'd1;
    localparam logic [1:0] MODE_LONG   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OSC  = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_GUARD = 2'd1,
        ERR_LARGE = 2'd2,
        ERR_OSC   = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLL_RUN,
        ST_MP_SCALE,
        ST_MP_CODE,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_ENC,
        ST_DEC_MUL,
        ST_FIN,
        ST_DONE
    } t_state;

    // Divisions run in this order after the two macro periods.
    typedef enum logic [2:0] {
        JOB_PHASECAL = 3'd0,
        JOB_MM_A     = 3'd1,
        JOB_RANGE_A  = 3'd2,
        JOB_MM_B     = 3'd3,
        JOB_RANGE_B  = 3'd4
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Result item, error code in the lowest bits.
    typedef struct packed {
        logic [31:0] recovered_budget;
        logic [15:0] range_timeout_b;
        logic [15:0] mm_timeout_b;
        logic [15:0] range_timeout_a;
        logic [15:0] mm_timeout_a;
        logic [7:0]  phasecal_timeout;
        logic [1:0]  error_code;
    } t_result;

endpackage

`default_nettype wire

/* design/rtbe_div.sv */
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module rtbe_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_dividend,
    input  wire logic [31:0]        i_divisor,
    output rtbe_pkg::t_div_stat     o_stat,
    output logic      [31:0]        o_quotient
);
    import rtbe_pkg::*;

    `include "ranging_timing_budget_encoder_macros.svh"

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;

    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        fits;

    // Shift in the next dividend bit and try the subtraction.
    // A zero divisor always fits, so the quotient comes out all ones.
    always_comb begin
        rem_sh   = {r_rem, r_quo[31]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        fits     = (rem_sh >= {1'b0, r_dvs});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    `RTBE_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "divider done held over two cycles")
    `RTBE_ASSERT_NEXT(a_busy_hold, r_busy && !i_start && r_cnt != 5'd31, r_busy,
        "divider dropped busy early")
    `RTBE_ASSERT(a_start_clear, $rose(r_busy), r_rem == 32'd0, "divider began with stale remainder")

endmodule

`default_nettype wire

/* design/ranging_timing_budget_encoder.sv */
// A request runs in order: the oscillator division on the shared divider, the scale and
// code multiplies for each of the two macro periods, then five divisions, each after a
// divider start step, with up to 24 normalizing shifts encoding each of the last four, and
// last the decode multiply and rounding. A rejected request goes straight to the result
// step. A new request is taken only once the previous result enters the free output register.
// Reset (synchronous, active low): idle, no result pending, oscillator 0, distance mode long.
`default_nettype none

module ranging_timing_budget_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data,
    // Input stream.
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: req_budget[20:0], zero pad [23:21]
    input  wire logic [rtbe_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // Output stream.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: error_code[1:0], phasecal_timeout[9:2], mm_timeout_a[25:10],
    // range_timeout_a[41:26], mm_timeout_b[57:42], range_timeout_b[73:58],
    // recovered_budget[105:74], zero pad [111:106]
    output logic      [rtbe_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import rtbe_pkg::*;

    `include "ranging_timing_budget_encoder_macros.svh"

    // Configuration registers.
    logic [15:0] r_osc;
    logic [1:0]  r_mode;

    // Sequencer and working registers.
    t_state      r_state, n_state;
    t_job        r_job, n_job;
    logic        r_side, n_side;
    t_err        r_err, n_err;
    logic [19:0] r_rt, n_rt;
    logic [31:0] r_pll, n_pll;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_mpa, n_mpa;
    logic [31:0] r_mpb, n_mpb;
    logic [31:0] r_ls, n_ls;
    logic [4:0]  r_ms, n_ms;
    logic [7:0]  r_pc, n_pc;
    logic [15:0] r_mma, n_mma;
    logic [15:0] r_ra, n_ra;
    logic [15:0] r_mmb, n_mmb;
    logic [15:0] r_rb, n_rb;
    logic [63:0] r_prod, n_prod;
    logic [31:0] r_eff, n_eff;

    // Output register.
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    // Shared units.
    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    t_div_stat   div_stat;
    logic [31:0] div_quo;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;

    // Helpers.
    logic [20:0] in_budget;
    t_err        in_err;
    logic        s_acc;
    logic [3:0]  code_a;
    logic [3:0]  code_b;
    logic [3:0]  code_sel;
    logic [5:0]  pclks;
    logic [31:0] job_us;
    logic [31:0] job_mp;
    logic [31:0] dec_val;
    logic [63:0] round_sum;
    logic [15:0] enc_word;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes past the list are ignored by construction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc  <= 16'd0;
            r_mode <= MODE_LONG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OSC:  r_osc  <= i_cfg_data;
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                default:  r_osc  <= r_osc;
            endcase
        end
    end

    // Budget and oscillator checks, in priority order.
    assign in_budget = i_s_tdata[20:0];
    always_comb begin
        priority if (in_budget <= GUARD_US) begin
            in_err = ERR_GUARD;
        end else if (in_budget > (GUARD_US + MAX_RANGE_US)) begin
            in_err = ERR_LARGE;
        end else if (r_osc == 16'd0) begin
            in_err = ERR_OSC;
        end else begin
            in_err = ERR_OK;
        end
    end

    // Pulse-period codes; the unused mode behaves as long.
    always_comb begin
        unique case (r_mode)
            MODE_SHORT: begin
                code_a = CODE_SHORT_A;
                code_b = CODE_SHORT_B;
            end
            MODE_MEDIUM: begin
                code_a = CODE_MEDIUM_A;
                code_b = CODE_MEDIUM_B;
            end
            default: begin
                code_a = CODE_LONG_A;
                code_b = CODE_LONG_B;
            end
        endcase
        code_sel = r_side ? code_b : code_a;
        pclks    = {2'b00, code_sel} + 6'd1;
        pclks    = {pclks[4:0], 1'b0};
    end

    // Division operands for the current job: ((us << 12) + mp / 2) / mp, wrapping.
    always_comb begin
        unique case (r_job)
            JOB_PHASECAL:          job_us = PHASECAL_US;
            JOB_MM_A, JOB_MM_B:    job_us = 32'd1;
            default:               job_us = {12'd0, r_rt};
        endcase
        job_mp = (r_job == JOB_MM_B || r_job == JOB_RANGE_B) ? r_mpb : r_mpa;
    end

    // Decode of range timeout A: (mantissa << exponent) + 1.
    always_comb begin
        if (r_ra[15:8] < 8'd32) begin
            dec_val = ({24'd0, r_ra[7:0]} << r_ra[12:8]) + 32'd1;
        end else begin
            dec_val = 32'd1;
        end
    end

    // Shared multiplier operands by sequencer step.
    always_comb begin
        unique case (r_state)
            ST_MP_SCALE: begin
                mul_a = r_pll;
                mul_b = MACRO_VCSEL_PERIODS;
            end
            ST_MP_CODE: begin
                mul_a = r_acc;
                mul_b = {26'd0, pclks};
            end
            default: begin
                mul_a = dec_val;
                mul_b = r_mpa;
            end
        endcase
    end
    assign mul_prod = mul_a * mul_b;

    assign round_sum = r_prod + ROUND_HALF;
    assign enc_word  = {3'b000, r_ms, r_ls[7:0]};

    // A new request is taken only while the sequencer is idle.
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Divider request: the oscillator division starts on acceptance, the rest from the sequencer.
    always_comb begin
        div_start    = (s_acc && in_err == ERR_OK) || (r_state == ST_DIV_START);
        div_dividend = (r_state == ST_IDLE) ? PLL_NUMERATOR : (job_us << 12) + (job_mp >> 1);
        div_divisor  = (r_state == ST_IDLE) ? {16'd0, r_osc} : job_mp;
    end

    rtbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer: next state and next values of the working registers.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_side      = r_side;
        n_err       = r_err;
        n_rt        = r_rt;
        n_pll       = r_pll;
        n_acc       = r_acc;
        n_mpa       = r_mpa;
        n_mpb       = r_mpb;
        n_ls        = r_ls;
        n_ms        = r_ms;
        n_pc        = r_pc;
        n_mma       = r_mma;
        n_ra        = r_ra;
        n_mmb       = r_mmb;
        n_rb        = r_rb;
        n_prod      = r_prod;
        n_eff       = r_eff;
        n_res       = r_res;
        n_out_valid = r_out_valid;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_err = in_err;
                    n_rt  = 20'((in_budget - GUARD_US) >> 1);
                    n_pc  = '0;
                    n_mma = '0;
                    n_ra  = '0;
                    n_mmb = '0;
                    n_rb  = '0;
                    n_eff = '0;
                    n_state = (in_err == ERR_OK) ? ST_PLL_RUN : ST_DONE;
                end
            end
            ST_PLL_RUN: begin
                if (div_stat.done) begin
                    n_pll   = div_quo;
                    n_side  = 1'b0;
                    n_state = ST_MP_SCALE;
                end
            end
            ST_MP_SCALE: begin
                // 2304 * pll wraps at 32 bits, then drops six bits.
                n_acc   = {6'd0, mul_prod[31:6]};
                n_state = ST_MP_CODE;
            end
            ST_MP_CODE: begin
                if (!r_side) begin
                    n_mpa   = {6'd0, mul_prod[31:6]};
                    n_side  = 1'b1;
                    n_state = ST_MP_SCALE;
                end else begin
                    n_mpb   = {6'd0, mul_prod[31:6]};
                    n_job   = JOB_PHASECAL;
                    n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                n_state = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (div_stat.done) begin
                    if (r_job == JOB_PHASECAL) begin
                        n_pc    = (div_quo > PC_MAX) ? 8'hFF : div_quo[7:0];
                        n_job   = JOB_MM_A;
                        n_state = ST_DIV_START;
                    end else begin
                        // A zero count encodes the same as a count of one.
                        n_ls    = (div_quo == 32'd0) ? 32'd0 : div_quo - 32'd1;
                        n_ms    = '0;
                        n_state = ST_ENC;
                    end
                end
            end
            ST_ENC: begin
                if ((r_ls & ENC_HIGH_MASK) != 32'd0) begin
                    n_ls = r_ls >> 1;
                    n_ms = r_ms + 5'd1;
                end else begin
                    unique case (r_job)
                        JOB_MM_A:    n_mma = enc_word;
                        JOB_RANGE_A: n_ra  = enc_word;
                        JOB_MM_B:    n_mmb = enc_word;
                        default:     n_rb  = enc_word;
                    endcase
                    if (r_job == JOB_RANGE_B) begin
                        n_state = ST_DEC_MUL;
                    end else begin
                        n_job   = t_job'(r_job + 3'd1);
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_DEC_MUL: begin
                n_prod  = mul_prod;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_eff   = {round_sum[42:12], 1'b0} + GUARD_US_32;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_res.error_code       = r_err;
                    n_res.phasecal_timeout = r_pc;
                    n_res.mm_timeout_a     = r_mma;
                    n_res.range_timeout_a  = r_ra;
                    n_res.mm_timeout_b     = r_mmb;
                    n_res.range_timeout_b  = r_rb;
                    n_res.recovered_budget = r_eff;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_side <= n_side;
        r_err  <= n_err;
        r_rt   <= n_rt;
        r_pll  <= n_pll;
        r_acc  <= n_acc;
        r_mpa  <= n_mpa;
        r_mpb  <= n_mpb;
        r_ls   <= n_ls;
        r_ms   <= n_ms;
        r_pc   <= n_pc;
        r_mma  <= n_mma;
        r_ra   <= n_ra;
        r_mmb  <= n_mmb;
        r_rb   <= n_rb;
        r_prod <= n_prod;
        r_eff  <= n_eff;
        r_res  <= n_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, r_res};

    `RTBE_ASSERT_NEXT(a_err_to_done, s_acc && in_err != ERR_OK, r_state == ST_DONE,
        "rejected budget did not go straight to the result step")
    `RTBE_ASSERT(a_div_free, div_start, !div_stat.busy, "division requested while divider busy")
    `RTBE_ASSERT(a_enc_exp, r_state == ST_ENC, r_ms <= 5'd24, "timeout exponent out of range")
    `RTBE_ASSERT(a_err_zero, r_state == ST_DONE && r_err != ERR_OK,
        r_pc == 8'd0 && r_ra == 16'd0 && r_rb == 16'd0 && r_eff == 32'd0,
        "error result carries nonzero fields")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the ranging timing budget encoder.
`timescale 1ns / 1ps

module tb;
    import rtbe_pkg::*;

    // Distance mode value with no named setting; it must act as long range.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 70;

    // Predicts the timeout registers for each budget request and checks the results.
    class budget_timeout_board;
        logic [15:0] osc_freq = '0;
        logic [1:0]  dist_mode = MODE_LONG;
        t_result     expected_q[$];
        int          fails = 0;

        function void set_register(logic index, logic [15:0] data);
            if (index == CFG_OSC) begin
                osc_freq = data;
            end else begin
                dist_mode = data[1:0];
            end
        endfunction

        // Macro period in 20.12 fixed point; all products wrap at 32 bits.
        function logic [31:0] macro_period(logic [3:0] code);
            logic [31:0] pll;
            logic [31:0] m;
            pll = PLL_NUMERATOR / {16'b0, osc_freq};
            m = MACRO_VCSEL_PERIODS * pll;
            m = m >> 6;
            m = m * (({28'b0, code} + 32'd1) << 1);
            m = m >> 6;
            return m;
        endfunction

        // A zero macro period saturates the count instead of dividing.
        function logic [31:0] to_mclks(logic [31:0] us, logic [31:0] mp);
            logic [31:0] num;
            if (mp == 32'd0) return 32'hFFFF_FFFF;
            num = (us << 12) + (mp >> 1);
            return num / mp;
        endfunction

        function logic [15:0] pack_timeout(logic [31:0] mclks);
            logic [31:0] ls;
            logic [7:0]  ms;
            if (mclks == 32'd0) return 16'd0;
            ls = mclks - 32'd1;
            ms = 8'd0;
            while ((ls & ENC_HIGH_MASK) != 32'd0) begin
                ls = ls >> 1;
                ms = ms + 8'd1;
            end
            return {ms, ls[7:0]};
        endfunction

        function logic [31:0] unpack_timeout(logic [15:0] enc);
            logic [31:0] v;
            v = (enc[15:8] < 8'd32) ? ({24'b0, enc[7:0]} << enc[15:8]) : 32'd0;
            return v + 32'd1;
        endfunction

        function t_result predict_timeouts(logic [20:0] budget);
            t_result     r;
            logic [31:0] half_span;
            logic [31:0] per_a;
            logic [31:0] per_b;
            logic [31:0] pc;
            logic [63:0] wide;
            logic [31:0] rec_us;
            logic [3:0]  ca;
            logic [3:0]  cb;
            r = '0;
            // Budget checks take precedence over the oscillator check.
            if (budget <= GUARD_US) begin
                r.error_code = ERR_GUARD;
            end else if (budget - GUARD_US > MAX_RANGE_US) begin
                r.error_code = ERR_LARGE;
            end else if (osc_freq == 16'd0) begin
                r.error_code = ERR_OSC;
            end
            if (r.error_code != ERR_OK) return r;

            half_span = {11'b0, budget - GUARD_US} >> 1;
            case (dist_mode)
                MODE_SHORT: begin
                    ca = CODE_SHORT_A;
                    cb = CODE_SHORT_B;
                end
                MODE_MEDIUM: begin
                    ca = CODE_MEDIUM_A;
                    cb = CODE_MEDIUM_B;
                end
                default: begin
                    ca = CODE_LONG_A;
                    cb = CODE_LONG_B;
                end
            endcase
            per_a = macro_period(ca);
            per_b = macro_period(cb);

            pc = to_mclks(PHASECAL_US, per_a);
            if (pc > PC_MAX) pc = PC_MAX;
            r.phasecal_timeout = pc[7:0];
            r.mm_timeout_a     = pack_timeout(to_mclks(32'd1, per_a));
            r.range_timeout_a  = pack_timeout(to_mclks(half_span, per_a));
            r.mm_timeout_b     = pack_timeout(to_mclks(32'd1, per_b));
            r.range_timeout_b  = pack_timeout(to_mclks(half_span, per_b));

            // Decode range timeout A back into microseconds, rounded.
            wide = {32'b0, unpack_timeout(r.range_timeout_a)} * {32'b0, per_a} + ROUND_HALF;
            rec_us = wide[43:12];
            r.recovered_budget = (rec_us << 1) + GUARD_US_32;
            return r;
        endfunction

        function void note_budget(logic [20:0] budget);
            expected_q.push_back(predict_timeouts(budget));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no pending request: expected none, actual %h",
                         $time, got);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("phasecal_timeout", want.phasecal_timeout, got.phasecal_timeout);
            compare_field("mm_timeout_a", want.mm_timeout_a, got.mm_timeout_a);
            compare_field("range_timeout_a", want.range_timeout_a, got.range_timeout_a);
            compare_field("mm_timeout_b", want.mm_timeout_b, got.mm_timeout_b);
            compare_field("range_timeout_b", want.range_timeout_b, got.range_timeout_b);
            compare_field("recovered_budget", want.recovered_budget,
                          got.recovered_budget);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = CFG_OSC;
    logic [15:0]           i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    budget_timeout_board timeout_board;
    bit                  steady = 1'b0;
    int                  next_in_gap = 1;
    int                  ready_left = 0;

    ranging_timing_budget_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Idle lengths: mostly short, now and then long, none in steady phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Downstream stalls alternate with runs of readiness.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (steady || $urandom_range(0, 1) == 0) begin
            i_m_tready <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end else begin
            i_m_tready <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    // Each accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            timeout_board.check_result(o_m_tdata[RES_W-1:0]);
        end
    end

    task automatic write_register(input logic index, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        timeout_board.set_register(index, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high across back-to-back requests and drops only for a gap.
    task automatic send_budget(input logic [20:0] budget);
        repeat (next_in_gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, budget};
        do @(posedge i_clk); while (!o_s_tready);
        timeout_board.note_budget(budget);
        next_in_gap = pick_gap();
        if (next_in_gap > 0) i_s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        if (next_in_gap == 0) begin
            i_s_tvalid <= 1'b0;
            next_in_gap = 1;
        end
        while (timeout_board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] osc, input logic [15:0] mode_word);
        drain_results();
        write_register(CFG_OSC, osc);
        write_register(CFG_MODE, mode_word);
    endtask

    function automatic logic [20:0] random_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 21'($urandom_range(GUARD_US + 1, GUARD_US + MAX_RANGE_US));
        if (r < 90) return 21'($urandom_range(0, 21'h1F_FFFF));
        case ($urandom_range(0, 6))
            0: return GUARD_US;
            1: return GUARD_US + 21'd1;
            2: return GUARD_US + MAX_RANGE_US;
            3: return GUARD_US + MAX_RANGE_US + 21'd1;
            4: return 21'd0;
            5: return 21'h1F_FFFF;
            default: return GUARD_US + 21'd2;
        endcase
    endfunction

    initial begin
        int          r;
        logic [15:0] osc;
        logic [15:0] mode_word;
        timeout_board = new;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every error path and both budget limits.
        send_budget(21'd0);
        send_budget(GUARD_US);
        send_budget(GUARD_US + 21'd1);
        send_budget(GUARD_US + MAX_RANGE_US);
        send_budget(GUARD_US + MAX_RANGE_US + 21'd1);
        send_budget(21'h1F_FFFF);
        send_budget(21'h15_5555);
        send_budget(21'h0A_AAAA);

        // Slowest oscillator: the macro period wraps to zero.
        configure(16'd1, {14'd0, MODE_SHORT});
        send_budget(GUARD_US + 21'd1);
        send_budget(GUARD_US + 21'd2);
        send_budget(GUARD_US + MAX_RANGE_US);
        send_budget(21'd600000);

        // Fastest oscillator, with junk in the unused mode bits.
        configure(16'hFFFF, {14'h3FFF, MODE_MEDIUM});
        send_budget(GUARD_US + 21'd1);
        send_budget(GUARD_US + MAX_RANGE_US);
        send_budget(21'h0A_AAAA);
        send_budget(21'h05_5555);

        // The spare distance mode behaves as long range.
        configure(16'hB0D2, {14'd0, MODE_SPARE});
        send_budget(GUARD_US + 21'd1);
        send_budget(GUARD_US + MAX_RANGE_US);
        send_budget(21'd500000);

        configure(16'd16, {14'd0, MODE_LONG});
        send_budget(GUARD_US + 21'd1);
        send_budget(GUARD_US + MAX_RANGE_US);

        configure(16'd0, {14'd0, MODE_SHORT});
        send_budget(21'd600000);

        // Random phases, each with its own oscillator and distance mode.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                osc = 16'd0;
            end else if (r < 20) begin
                osc = 16'($urandom_range(1, 64));
            end else if (r < 60) begin
                osc = 16'($urandom_range(16'h8000, 16'hFFFF));
            end else begin
                osc = 16'($urandom_range(1, 16'hFFFF));
            end
            mode_word = 16'($urandom);
            if (phase == RANDOM_PHASES - 1) mode_word[1:0] = MODE_LONG;
            configure(osc, mode_word);
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_budget(random_budget());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (timeout_board.fails == 0 && timeout_board.pending() == 0) begin
            $display("PASS ranging_timing_budget_encoder");
        end else begin
            $display("FAIL ranging_timing_budget_encoder");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("FAIL ranging_timing_budget_encoder");
        $finish;
    end

endmodule
